[rtl/lpwc_pkg.sv]
package lpwc_pkg;

    localparam int unsigned OUT_DEPTH_DEF = 4;

    localparam logic [15:0] WINDOW_LENGTH_RESET = 16'd60;

    localparam logic [7:0] CODE_SAT     = 8'hFF;
    localparam logic [7:0] CODE_NAT_MAX = 8'hEF;
    localparam logic [4:0] EXP_MAX      = 5'd15;
    localparam logic [4:0] MANT_BITS    = 5'd4;

    localparam logic KIND_REALTIME = 1'b0;
    localparam logic KIND_PEAK     = 1'b1;

    typedef struct packed {
        logic [23:0] uv_raw;
        logic [23:0] vis_raw;
    } sample_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  uv_code;
        logic [7:0]  vis_code;
        logic [31:0] timestamp;
        logic        last;
    } result_t;

    // one accepted sample with the context it needs for both results
    typedef struct packed {
        logic [23:0] uv;
        logic [23:0] vis;
        logic [31:0] timestamp;
        logic        close;
        logic [23:0] peak_uv;
        logic [23:0] peak_vis;
    } job_t;

    typedef struct packed {
        result_t rt;
        result_t pk;
        logic    two;
    } enc_t;

endpackage

[rtl/lpwc_track.sv]
module lpwc_track (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [15:0]    cfg_data,
    input  logic           accept,
    input  lpwc_pkg::sample_t sample,
    input  logic           advance,
    output logic           job_valid,
    output lpwc_pkg::job_t job
);
    import lpwc_pkg::*;

    logic [15:0] window_length_reg;
    logic [31:0] second_count_reg;
    logic [15:0] window_count_reg;
    logic [23:0] peak_uv_reg;
    logic [23:0] peak_vis_reg;
    logic        job_valid_reg;
    job_t        job_reg;

    logic [15:0] window_count_inc;
    logic        close;
    logic [23:0] peak_uv_new;
    logic [23:0] peak_vis_new;
    job_t        job_next;

    always_comb
    begin
        window_count_inc = window_count_reg + 16'd1;
        close            = (window_count_inc >= window_length_reg);
        peak_uv_new      = (sample.uv_raw > peak_uv_reg) ? sample.uv_raw : peak_uv_reg;
        peak_vis_new     = (sample.vis_raw > peak_vis_reg) ? sample.vis_raw : peak_vis_reg;

        job_next.uv        = sample.uv_raw;
        job_next.vis       = sample.vis_raw;
        job_next.timestamp = second_count_reg;
        job_next.close     = close;
        job_next.peak_uv   = peak_uv_new;
        job_next.peak_vis  = peak_vis_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= WINDOW_LENGTH_RESET;
            second_count_reg  <= '0;
            window_count_reg  <= '0;
            peak_uv_reg       <= '0;
            peak_vis_reg      <= '0;
            job_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                window_length_reg <= cfg_data;
            end
            if (accept)
            begin
                second_count_reg <= second_count_reg + 32'd1;
                window_count_reg <= close ? 16'd0 : window_count_inc;
                peak_uv_reg      <= close ? 24'd0 : peak_uv_new;
                peak_vis_reg     <= close ? 24'd0 : peak_vis_new;
                job_valid_reg    <= 1'b1;
            end
            else if (advance)
            begin
                job_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg <= job_next;
        end
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;

endmodule

[rtl/lpwc_encode.sv]
module lpwc_encode (
    input  lpwc_pkg::job_t job,
    output lpwc_pkg::enc_t enc
);
    import lpwc_pkg::*;

    function automatic logic [7:0] clamp_uv(input logic [23:0] v);
        return (v > 24'd255) ? CODE_SAT : v[7:0];
    endfunction

    // 4-bit rounded mantissa over 4-bit exponent
    function automatic logic [7:0] compress_vis(input logic [23:0] v);
        logic [4:0]  bits;
        logic [4:0]  e;
        logic [4:0]  sh;
        logic [4:0]  mpre;
        logic [5:0]  mr;
        logic [3:0]  m;
        logic [7:0]  code;
        bits = 5'd0;
        for (int i = 0; i < 24; i++)
        begin
            if (v[i])
            begin
                bits = 5'(i + 1);
            end
        end
        e    = (bits < MANT_BITS) ? 5'd0 : bits - MANT_BITS;
        sh   = e - 5'd1;
        mpre = 5'(v >> sh);
        mr   = (6'(mpre) + 6'd1) >> 1;
        if (mr[4])
        begin
            m = 4'd8;
            e = e + 5'd1;
        end
        else
        begin
            m = mr[3:0];
        end
        if (bits > (EXP_MAX + MANT_BITS) || e > EXP_MAX)
        begin
            code = CODE_SAT;
        end
        else if (bits <= MANT_BITS)
        begin
            code = {v[3:0], 4'h0};
        end
        else
        begin
            code = {m, e[3:0]};
        end
        // natural all-ones code would read as saturated
        if (code == CODE_SAT && bits <= (EXP_MAX + MANT_BITS) && e <= EXP_MAX)
        begin
            code = CODE_NAT_MAX;
        end
        return code;
    endfunction

    always_comb
    begin
        enc.rt.kind      = KIND_REALTIME;
        enc.rt.uv_code   = clamp_uv(job.uv);
        enc.rt.vis_code  = compress_vis(job.vis);
        enc.rt.timestamp = job.timestamp;
        enc.rt.last      = !job.close;

        enc.pk.kind      = KIND_PEAK;
        enc.pk.uv_code   = clamp_uv(job.peak_uv);
        enc.pk.vis_code  = compress_vis(job.peak_vis);
        enc.pk.timestamp = 32'd0;
        enc.pk.last      = 1'b1;

        enc.two          = job.close;
    end

endmodule

[rtl/lpwc_outq.sv]
module lpwc_outq #(
    parameter int unsigned DEPTH = lpwc_pkg::OUT_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lpwc_pkg::enc_t    enc,
    output logic              room,
    output logic              result_valid,
    input  logic              result_stall,
    output lpwc_pkg::result_t result
);
    import lpwc_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    result_t         mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic [PW-1:0]   wr_ptr_inc;
    logic [CW-1:0]   push_n;
    logic            pop;

    function automatic logic [PW-1:0] inc_ptr(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign wr_ptr_inc   = inc_ptr(wr_ptr_reg);
    assign push_n       = push ? (enc.two ? CW'(2) : CW'(1)) : '0;
    assign pop          = result_valid && !result_stall;
    // space for the worst case of two words per sample
    assign room         = (count_reg <= CW'(DEPTH - 2));
    assign result_valid = (count_reg != '0);
    assign result       = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= enc.two ? inc_ptr(wr_ptr_inc) : wr_ptr_inc;
            end
            if (pop)
            begin
                rd_ptr_reg <= inc_ptr(rd_ptr_reg);
            end
            count_reg <= count_reg + push_n - (pop ? CW'(1) : CW'(0));
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= enc.rt;
            if (enc.two)
            begin
                mem[wr_ptr_inc] <= enc.pk;
            end
        end
    end

endmodule

[rtl/light_peak_window_compressor_top.sv]
// channel | direction | handshake                    | word
// sample  | in        | sample_valid / sample_stall  | uv_raw, vis_raw
// result  | out       | result_valid / result_stall  | kind, uv_code, vis_code, timestamp, last
// config  | in        | cfg_we                       | cfg_data = window_length
//
// One sample per cycle unless sample_stall; a sample closing a window gives two words.
// Path: sample register, then encode into the output queue; result_valid rises
// once the encoded words of an accepted sample are pushed into the queue.
// Result port sets throughput: one word per cycle leaves the queue unless stalled.
// Reset clears counters, maxima and queue; window_length returns to 60.
// result_stall backs up the queue, then the sample register, then sample_stall.
module light_peak_window_compressor_top #(
    parameter int unsigned OUT_DEPTH = lpwc_pkg::OUT_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [15:0]       cfg_data,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  lpwc_pkg::sample_t sample,
    output logic              result_valid,
    input  logic              result_stall,
    output lpwc_pkg::result_t result
);
    import lpwc_pkg::*;

    logic  accept;
    logic  advance;
    logic  room;
    logic  job_valid;
    job_t  job;
    enc_t  enc;

    assign advance      = job_valid && room;
    assign sample_stall = job_valid && !room;
    assign accept       = sample_valid && !sample_stall;

    lpwc_track u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .sample    (sample),
        .advance   (advance),
        .job_valid (job_valid),
        .job       (job)
    );

    lpwc_encode u_encode (
        .job (job),
        .enc (enc)
    );

    lpwc_outq #(
        .DEPTH (OUT_DEPTH)
    ) u_outq (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (advance),
        .enc          (enc),
        .room         (room),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

[rtl/lpwc_check.sv]
module lpwc_check (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    input  logic              sample_stall,
    input  logic              result_valid,
    input  logic              result_stall,
    input  lpwc_pkg::result_t result
);
    import lpwc_pkg::*;

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

    a_peak_shape: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind == KIND_PEAK |-> result.last && result.timestamp == 32'd0)
    else $error("peak word without last or with timestamp");

    a_peak_follows: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && result.kind == KIND_REALTIME && !result.last
        |=> result_valid && result.kind == KIND_PEAK)
    else $error("peak word missing after open real-time word");

    a_peak_sat_free: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind == KIND_REALTIME && result.last
        |=> !(result_valid && result.kind == KIND_PEAK && $past(result_valid && result_stall)))
    else $error("peak word replaced a stalled real-time word");

    // an empty output queue always has room for the next sample
    a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !result_valid |-> !sample_stall)
    else $error("sample stalled while no result word is waiting");

endmodule

bind light_peak_window_compressor_top lpwc_check u_lpwc_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
